@@ rtl/core/suldm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suldm_pkg
// Types, codes and defaults shared by the sorted-list priority queue.
// ----------------------------------------------------------------------------
package suldm_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 7;
    localparam int STATUS_W      = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
        logic signed [VALUE_W-1:0] min_value;
        logic                      min_valid;
    } rsp_item_t;

    // broadcast to every cell: compare phase, then the commit
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

endpackage

@@ rtl/core/suldm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suldm_cell
// One place of the sorted list: holds an entry, compares it against the
// broadcast value and shifts towards or away from its neighbours.
// ----------------------------------------------------------------------------
module suldm_cell
    import suldm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int INDEX    = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cell_cmd_t                         cmd,
    input  logic [$clog2(CAPACITY+1)-1:0]     count,
    input  logic signed [VALUE_W-1:0]         cmp_value,
    input  logic signed [VALUE_W-1:0]         ins_value,
    input  logic signed [VALUE_W-1:0]         prev_value,
    input  logic                              prev_ge,
    input  logic signed [VALUE_W-1:0]         next_value,
    output logic signed [VALUE_W-1:0]         value,
    output logic                              ge,
    output logic                              eq,
    output logic signed [VALUE_W-1:0]         value_next
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] value_reg;
    logic                      ge_reg;
    logic                      eq_reg;
    logic                      occupied;

    assign occupied = CNT_W'(INDEX) < count;

    // empty places count as "not smaller", so the first such place is the slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (cmd.cmp)
        begin
            ge_reg <= !occupied || (value_reg >= cmp_value);
            eq_reg <= occupied && (value_reg == cmp_value);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (ge_reg && !prev_ge)
                value_next = ins_value;
            else if (prev_ge)
                value_next = prev_value;
        end
        else if (cmd.del)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

@@ rtl/core/suldm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suldm_ctrl
// Sequencer, entry count, status decode and result register.
// ----------------------------------------------------------------------------
module suldm_ctrl
    import suldm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  req_item_t                         req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output rsp_item_t                         rsp,
    output cell_cmd_t                         cmd,
    output logic [$clog2(CAPACITY+1)-1:0]     count,
    output logic signed [VALUE_W-1:0]         ins_value,
    input  logic                              dup,
    input  logic signed [VALUE_W-1:0]         head_next
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

    state_t             state_reg;
    state_t             state_next;
    req_item_t          item_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               accept;
    logic               go;
    logic               full;
    logic [STATUS_W-1:0] status;
    logic [EXT_W-1:0]   count_ext;

    assign accept = req_valid && !req_stall;
    assign full   = count_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_BUSY;
            end
            S_BUSY:
            begin
                if (go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commit only once the result register is free or draining
    always_comb
    begin
        req_stall = 1'b0;
        go        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_BUSY:
            begin
                req_stall = 1'b1;
                go        = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cmd.cmp    = accept;
        cmd.ins    = 1'b0;
        cmd.del    = 1'b0;
        status     = STAT_INSERTED;
        count_next = count_reg;
        if (go)
        begin
            if (item_reg.op == OP_INSERT)
            begin
                if (dup)
                begin
                    status = STAT_DUPLICATE;
                end
                else if (full)
                begin
                    status = STAT_FULL;
                end
                else
                begin
                    cmd.ins    = 1'b1;
                    count_next = count_reg + 1'b1;
                    status     = STAT_INSERTED;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status = STAT_EMPTY;
                end
                else
                begin
                    cmd.del    = 1'b1;
                    count_next = count_reg - 1'b1;
                    status     = STAT_REMOVED;
                end
            end
        end
    end

    assign count_ext = EXT_W'(count_next);

    always_comb
    begin
        rsp_next.status      = status;
        rsp_next.entry_count = count_ext[ENTRY_COUNT_W-1:0];
        rsp_next.min_valid   = count_next != '0;
        rsp_next.min_value   = (count_next != '0) ? head_next : '0;

        rsp_valid_next = rsp_valid_reg;
        if (go)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
        if (go)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign count     = count_reg;
    assign ins_value = item_reg.value;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_BUSY)
        else $error("transfer taken but no compare phase followed");

    a_ins_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not bump the count");

    a_dup_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (go && item_reg.op == OP_INSERT && dup) |=> $stable(count_reg)
            && rsp_valid && rsp.status == STAT_DUPLICATE)
        else $error("duplicate insert altered the list");

endmodule

@@ rtl/core/sorted_unique_list_delete_min.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_list_delete_min
// Priority queue of distinct signed values kept as an ascending row of cells.
// ----------------------------------------------------------------------------
// Each transfer has a compare phase and then a commit: in the cycle it is taken
// every cell compares its entry against the incoming value and registers the
// result, and at the commit the whole row shifts at once (right of the slot on
// insert, left on delete-min) while the result is written to the output
// register. A new item is taken in the cycle after that commit, even while the
// previous result still waits, but never before the previous item commits; the
// commit waits only while a result is held back by rsp_stall. Duplicate
// detection is a reduction across all CAPACITY compare flags in the commit
// cycle. No clearing pass: entries above the count are never read.
// ----------------------------------------------------------------------------
module sorted_unique_list_delete_min
    import suldm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_cmd_t                 cmd;
    logic [CNT_W-1:0]          count;
    logic signed [VALUE_W-1:0] ins_value;
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic signed [VALUE_W-1:0] cell_value_next [CAPACITY];
    logic [CAPACITY-1:0]       ge_bits;
    logic [CAPACITY-1:0]       eq_bits;
    logic                      dup;

    suldm_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .count     (count),
        .ins_value (ins_value),
        .dup       (dup),
        .head_next (cell_value_next[0])
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] prev_value;
        logic                      prev_ge;
        logic signed [VALUE_W-1:0] next_value;

        if (i == 0)
        begin : g_head
            assign prev_value = '0;
            assign prev_ge    = 1'b0;
        end
        else
        begin : g_body
            assign prev_value = cell_value[i-1];
            assign prev_ge    = ge_bits[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_value = cell_value[i];
        end
        else
        begin : g_link
            assign next_value = cell_value[i+1];
        end

        suldm_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .count      (count),
            .cmp_value  (req.value),
            .ins_value  (ins_value),
            .prev_value (prev_value),
            .prev_ge    (prev_ge),
            .next_value (next_value),
            .value      (cell_value[i]),
            .ge         (ge_bits[i]),
            .eq         (eq_bits[i]),
            .value_next (cell_value_next[i])
        );
    end

    // entries are distinct, so at most one cell can match
    assign dup = |eq_bits;

    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_bits))
        else $error("more than one cell holds the same value");

    a_ge_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (ge_bits[CAPACITY-2:0] & ~ge_bits[CAPACITY-1:1]) == '0)
        else $error("compare flags not monotone along the row");

endmodule
